/* rtl/core/gsoc_pkg.sv */
// ----------------------------------------------------------------------------
// gsoc_pkg
// Shared types and constants of the group segment order checker.
// ----------------------------------------------------------------------------
package gsoc_pkg;

  localparam int NumGroups  = 256;
  localparam int SlotW      = $clog2(NumGroups);
  localparam int GroupW     = 8;
  localparam int PrioW      = 16;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int EpochW     = 8;

  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = '1;

  typedef enum logic [1:0] {
    ActStart = 2'd0,
    ActBody  = 2'd1,
    ActTail  = 2'd2
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [GroupW-1:0]   group_id;
    logic [PrioW-1:0]    priority_req;
    logic                is_default;
  } queue_item_t;

  typedef struct packed {
    logic failed;
    logic start_fire;
    logic tail_fire;
  } back_status_t;

  function automatic logic [SlotW-1:0] slot_of(logic [GroupW-1:0] g);
    return SlotW'(g % NumGroups);
  endfunction

endpackage

/* rtl/core/group_segment_order_check.sv */
// ----------------------------------------------------------------------------
// group_segment_order_check
// Checks a route segment against group visiting order and gives one verdict
// per tail location.
// ----------------------------------------------------------------------------
//   Channel  Signals                                             Direction
//   in       in_valid_i/in_ready_o, action_i, group_id_i,        input
//            priority_req_i, is_default_i
//   out      out_valid_o/out_ready_i, feasible_o                 output
//
// One transaction per cycle is taken while the visited table is not being
// cleared and no verdict is stalled; a tail verdict passes through the
// two-entry queue, the registered read of the visited table and the check
// stage with its output register.
// After reset the visited table is cleared in a pass over its 256 entries
// before the first transaction is checked; the same pass follows every 255th
// start transaction, when the epoch counter wraps.
// A stalled verdict holds the check stage; the queue then fills and
// in_ready_o drops when it holds two entries.
// ----------------------------------------------------------------------------
module group_segment_order_check import gsoc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [GroupW-1:0]  group_id_i,
  input  logic [PrioW-1:0]   priority_req_i,
  input  logic               is_default_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               feasible_o
);

  logic                  push;
  logic                  q_full;
  logic                  q_valid;
  logic                  pop;
  logic [QueueCntW-1:0]  q_count;
  queue_item_t           push_item;
  queue_item_t           head_item;
  back_status_t          status;

  gsoc_front u_front (
    .in_valid_i     (in_valid_i),
    .action_i       (action_i),
    .group_id_i     (group_id_i),
    .priority_req_i (priority_req_i),
    .is_default_i   (is_default_i),
    .q_full_i       (q_full),
    .in_ready_o     (in_ready_o),
    .push_o         (push),
    .item_o         (push_item)
  );

  gsoc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (head_item),
    .count_o (q_count)
  );

  gsoc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .pop_o       (pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .feasible_o  (feasible_o),
    .status_o    (status)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (action_i == ActStart || action_i == ActBody || action_i == ActTail))
    else $error("unused action code entered the queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.start_fire |=> !status.failed)
    else $error("start transaction did not clear the check state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(status.tail_fire))
    else $error("verdict raised without a tail transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_count == QueueCntW'(QueueDepth)) |-> !in_ready_o)
    else $error("input accepted while the queue is full");

endmodule

/* rtl/core/gsoc_front.sv */
// ----------------------------------------------------------------------------
// gsoc_front
// Accepts input transactions, decodes the action and drops unused codes.
// ----------------------------------------------------------------------------
module gsoc_front import gsoc_pkg::*; (
  input  logic                in_valid_i,
  input  logic [1:0]          action_i,
  input  logic [GroupW-1:0]   group_id_i,
  input  logic [PrioW-1:0]    priority_req_i,
  input  logic                is_default_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output queue_item_t         item_o
);

  logic known;

  always_comb begin
    case (action_i)
      ActStart: known = 1'b1;
      ActBody:  known = 1'b1;
      ActTail:  known = 1'b1;
      default:  known = 1'b0;
    endcase
  end

  assign in_ready_o          = !q_full_i;
  assign push_o              = in_valid_i && !q_full_i && known;
  assign item_o.action       = action_e'(action_i);
  assign item_o.group_id     = group_id_i;
  assign item_o.priority_req = priority_req_i;
  assign item_o.is_default   = is_default_i;

endmodule

/* rtl/core/gsoc_queue.sv */
// ----------------------------------------------------------------------------
// gsoc_queue
// Short queue between the front and the back.
// ----------------------------------------------------------------------------
module gsoc_queue import gsoc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  queue_item_t           item_i,
  input  logic                  pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output queue_item_t           item_o,
  output logic [QueueCntW-1:0]  count_o
);

  queue_item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]        wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]        count_q, count_d;
  logic                        do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/core/gsoc_back.sv */
// ----------------------------------------------------------------------------
// gsoc_back
// Runs the group order checks and holds the verdict for the output channel.
// ----------------------------------------------------------------------------
module gsoc_back import gsoc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  queue_item_t   q_item_i,
  output logic          pop_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic          feasible_o,
  output back_status_t  status_o
);

  // A group counts as visited when its tag equals the current epoch.
  logic [EpochW-1:0]     tag_mem [NumGroups];
  logic [EpochW-1:0]     tag_rd_q;
  queue_item_t           ex_item_q, ex_item_d;
  logic                  ex_valid_q, ex_valid_d;
  logic                  fwd_hit_q, fwd_hit_d;
  logic [EpochW-1:0]     epoch_q, epoch_d;
  logic                  sweep_q, sweep_d;
  logic [SlotW-1:0]      sweep_idx_q, sweep_idx_d;
  logic [GroupW-1:0]     prev_group_q, prev_group_d;
  logic [PrioW-1:0]      prev_prio_q, prev_prio_d;
  logic                  prev_dflt_q, prev_dflt_d;
  logic                  failed_q, failed_d;
  logic                  out_valid_q, out_valid_d;
  logic                  feasible_q, feasible_d;
  logic                  ex_fire;
  logic                  ex_tail;
  logic                  ex_start;
  logic                  wrap_start;
  logic                  hit_visited;
  logic                  same_group;
  logic                  prio_low;
  logic                  mark_en;
  logic [SlotW-1:0]      mark_slot;
  logic [SlotW-1:0]      rd_slot;
  logic                  wr_en;
  logic [SlotW-1:0]      wr_slot;
  logic [EpochW-1:0]     wr_tag;

  assign ex_tail     = (ex_item_q.action == ActTail);
  assign ex_fire     = ex_valid_q && (!ex_tail || !out_valid_q || out_ready_i);
  assign ex_start    = ex_fire && (ex_item_q.action == ActStart);
  assign wrap_start  = ex_start && (epoch_q == EpochLast);
  assign pop_o       = q_valid_i && !sweep_q && !wrap_start && (!ex_valid_q || ex_fire);
  assign rd_slot     = slot_of(q_item_i.group_id);
  assign hit_visited = fwd_hit_q || (tag_rd_q == epoch_q);
  assign same_group  = (prev_group_q == ex_item_q.group_id);
  assign prio_low    = (ex_item_q.priority_req < prev_prio_q);
  assign mark_slot   = slot_of(prev_group_q);
  assign mark_en     = ex_fire && (ex_item_q.action == ActBody) && !prev_dflt_q &&
                       !same_group;
  assign wr_en       = sweep_q || mark_en;
  assign wr_slot     = sweep_q ? sweep_idx_q : mark_slot;
  assign wr_tag      = sweep_q ? '0 : epoch_q;

  always_comb begin
    ex_item_d    = pop_o ? q_item_i : ex_item_q;
    ex_valid_d   = pop_o || (ex_valid_q && !ex_fire);
    fwd_hit_d    = pop_o ? (mark_en && (mark_slot == rd_slot)) : fwd_hit_q;
    epoch_d      = epoch_q;
    sweep_d      = sweep_q;
    sweep_idx_d  = sweep_idx_q;
    prev_group_d = prev_group_q;
    prev_prio_d  = prev_prio_q;
    prev_dflt_d  = prev_dflt_q;
    failed_d     = failed_q;
    feasible_d   = feasible_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    if (sweep_q) begin
      sweep_idx_d = sweep_idx_q + 1'b1;
      if (sweep_idx_q == SlotW'(NumGroups - 1)) begin
        sweep_d     = 1'b0;
        sweep_idx_d = '0;
      end
    end
    if (ex_fire) begin
      case (ex_item_q.action)
        ActStart: begin
          failed_d     = 1'b0;
          prev_group_d = ex_item_q.group_id;
          prev_prio_d  = ex_item_q.priority_req;
          prev_dflt_d  = ex_item_q.is_default;
          if (wrap_start) begin
            epoch_d     = EpochFirst;
            sweep_d     = 1'b1;
            sweep_idx_d = '0;
          end else begin
            epoch_d = epoch_q + 1'b1;
          end
        end
        ActBody: begin
          if (hit_visited) begin
            failed_d = 1'b1;
          end
          if (prev_dflt_q || !same_group) begin
            prev_group_d = ex_item_q.group_id;
            prev_prio_d  = ex_item_q.priority_req;
            prev_dflt_d  = ex_item_q.is_default;
          end else if (prio_low) begin
            failed_d = 1'b1;
          end
        end
        ActTail: begin
          out_valid_d = 1'b1;
          feasible_d  = !(failed_q || hit_visited || (same_group && prio_low));
        end
        default: begin
          out_valid_d = out_valid_q && !out_ready_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_item_q    <= '0;
      ex_valid_q   <= 1'b0;
      fwd_hit_q    <= 1'b0;
      epoch_q      <= EpochFirst;
      sweep_q      <= 1'b1;
      sweep_idx_q  <= '0;
      prev_group_q <= '0;
      prev_prio_q  <= '0;
      prev_dflt_q  <= 1'b0;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      ex_item_q    <= ex_item_d;
      ex_valid_q   <= ex_valid_d;
      fwd_hit_q    <= fwd_hit_d;
      epoch_q      <= epoch_d;
      sweep_q      <= sweep_d;
      sweep_idx_q  <= sweep_idx_d;
      prev_group_q <= prev_group_d;
      prev_prio_q  <= prev_prio_d;
      prev_dflt_q  <= prev_dflt_d;
      failed_q     <= failed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[wr_slot] <= wr_tag;
    end
    if (pop_o) begin
      tag_rd_q <= tag_mem[rd_slot];
    end
  end

  always_ff @(posedge clk_i) begin
    feasible_q <= feasible_d;
  end

  assign out_valid_o         = out_valid_q;
  assign feasible_o          = feasible_q;
  assign status_o.failed     = failed_q;
  assign status_o.start_fire = ex_start;
  assign status_o.tail_fire  = ex_fire && ex_tail;

endmodule
